// ===== src/md5_pkg.sv =====
// md5_pkg: payload structs, control structs and MD5 constant tables.
// No dependencies; imported by md5_front, md5_core, md5_back and md5_message_digest.
`timescale 1ns / 1ps
package md5_pkg;

    localparam int WordW      = 32;
    localparam int BufWords   = 16;
    localparam int WordIdxW   = $clog2(BufWords);
    localparam int RoundIdxW  = 6;

    localparam logic [WordW-1:0] InitA = 32'h67452301;
    localparam logic [WordW-1:0] InitB = 32'hefcdab89;
    localparam logic [WordW-1:0] InitC = 32'h98badcfe;
    localparam logic [WordW-1:0] InitD = 32'h10325476;
    localparam logic [7:0]       PadByte = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last;
    } in_t;

    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_low;
    } out_t;

    typedef struct packed {
        logic start;
        logic init;
    } core_ctl_t;

    typedef struct packed {
        logic done;
    } core_sts_t;

    function automatic logic [WordW-1:0] md5_k(input logic [RoundIdxW-1:0] i);
        logic [WordW-1:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_rot(input logic [RoundIdxW-1:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    // message word index used by round i
    function automatic logic [WordIdxW-1:0] md5_g(input logic [RoundIdxW-1:0] i);
        logic [WordIdxW-1:0] n;
        logic [WordIdxW-1:0] g;
        n = i[WordIdxW-1:0];
        case (i[5:4])
            2'd0:    g = n;
            2'd1:    g = WordIdxW'(n * 4'd5 + 4'd1);
            2'd2:    g = WordIdxW'(n * 4'd3 + 4'd5);
            default: g = WordIdxW'(n * 4'd7);
        endcase
        return g;
    endfunction

    function automatic logic [WordW-1:0] bswap32(input logic [WordW-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

// ===== src/md5_ram.sv =====
// md5_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/md5_front.sv =====
// md5_front: accepts input beats, drops beats with neither flag, queues the rest.
// Depends on md5_pkg.
`timescale 1ns / 1ps
module md5_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  md5_pkg::in_t  s_data,
    output logic          q_valid,
    input  logic          q_ready,
    output md5_pkg::in_t  q_data
);
    import md5_pkg::*;

    in_t        slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready && (s_data.byte_present || s_data.last);
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= s_data;
        end
    end
endmodule

// ===== src/md5_core.sv =====
// md5_core: chaining words and one-round-per-cycle MD5 compression.
// Depends on md5_pkg; reads message words from the block buffer RAM.
`timescale 1ns / 1ps
module md5_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  md5_pkg::core_ctl_t                ctl,
    output md5_pkg::core_sts_t                sts,
    output logic [md5_pkg::WordIdxW-1:0]      rd_addr,
    input  logic [md5_pkg::WordW-1:0]         rd_data,
    output logic [4*md5_pkg::WordW-1:0]       chain
);
    import md5_pkg::*;

    typedef enum logic [1:0] {C_IDLE, C_PREP, C_ROUND, C_ADD} cstate_t;

    cstate_t              state_reg, state_next;
    logic [RoundIdxW-1:0] round_reg, round_next;
    logic [WordW-1:0]     h_reg [4];
    logic [WordW-1:0]     a_reg, b_reg, c_reg, d_reg;
    logic [WordW-1:0]     f, sum;
    logic [2*WordW-1:0]   rot;

    always_comb begin
        case (round_reg[5:4])
            2'd0:    f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2:    f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        sum = a_reg + f + md5_k(round_reg) + rd_data;
        rot = {sum, sum} << md5_rot(round_reg);
    end

    // prefetch the word for the next round
    assign rd_addr  = (state_reg == C_ROUND) ? md5_g(round_reg + 6'd1) : md5_g(6'd0);
    assign sts.done = (state_reg == C_ADD);
    assign chain    = {h_reg[0], h_reg[1], h_reg[2], h_reg[3]};

    always_comb begin
        state_next = state_reg;
        round_next = round_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (ctl.start) begin
                    state_next = C_PREP;
                    round_next = '0;
                end
            end
            C_PREP:  state_next = C_ROUND;
            C_ROUND: begin
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63) begin
                    state_next = C_ADD;
                end
            end
            C_ADD:   state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            h_reg[0]  <= InitA;
            h_reg[1]  <= InitB;
            h_reg[2]  <= InitC;
            h_reg[3]  <= InitD;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
            if (ctl.init) begin
                h_reg[0] <= InitA;
                h_reg[1] <= InitB;
                h_reg[2] <= InitC;
                h_reg[3] <= InitD;
            end else if (state_reg == C_ADD) begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
            end
        end
        if (state_reg == C_PREP) begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
        end else if (state_reg == C_ROUND) begin
            a_reg <= d_reg;
            b_reg <= b_reg + rot[2*WordW-1:WordW];
            c_reg <= b_reg;
            d_reg <= c_reg;
        end
    end
endmodule

// ===== src/md5_back.sv =====
// md5_back: block buffer fill, padding sequencer and digest output register.
// Depends on md5_pkg, md5_ram and md5_core.
`timescale 1ns / 1ps
module md5_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  md5_pkg::in_t  q_data,
    output logic          m_valid,
    input  logic          m_ready,
    output md5_pkg::out_t m_data
);
    import md5_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_PAD, B_FILL, B_KICK, B_WAIT, B_DONE} bstate_t;

    bstate_t             state_reg, state_next;
    bstate_t             ret_reg, ret_next;
    logic [63:0]         bit_count_reg, bit_count_next;
    logic [WordW-1:0]    word_reg, word_next;
    logic [WordIdxW-1:0] widx_reg, widx_next;
    logic                two_blk_reg, two_blk_next;
    logic                out_valid_reg, out_valid_next;
    out_t                out_reg, out_next;

    logic [5:0]          pos;
    logic                we;
    logic [WordIdxW-1:0] waddr;
    logic [WordW-1:0]    wdata, byte_word, pad_word;
    logic [WordIdxW-1:0] rd_addr;
    logic [WordW-1:0]    rd_data;
    logic [4*WordW-1:0]  chain;
    core_ctl_t           core_ctl;
    core_sts_t           core_sts;

    md5_ram #(.WIDTH(WordW), .DEPTH(BufWords)) u_buf (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    md5_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (core_ctl),
        .sts     (core_sts),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .chain   (chain)
    );

    assign pos     = bit_count_reg[8:3];
    assign q_ready = (state_reg == B_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        case (pos[1:0])
            2'd0: begin
                byte_word = {word_reg[31:8], q_data.data_byte};
                pad_word  = {24'd0, PadByte};
            end
            2'd1: begin
                byte_word = {word_reg[31:16], q_data.data_byte, word_reg[7:0]};
                pad_word  = {16'd0, PadByte, word_reg[7:0]};
            end
            2'd2: begin
                byte_word = {word_reg[31:24], q_data.data_byte, word_reg[15:0]};
                pad_word  = {8'd0, PadByte, word_reg[15:0]};
            end
            default: begin
                byte_word = {q_data.data_byte, word_reg[23:0]};
                pad_word  = {PadByte, word_reg[23:0]};
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        bit_count_next = bit_count_reg;
        word_next      = word_reg;
        widx_next      = widx_reg;
        two_blk_next   = two_blk_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        we             = 1'b0;
        waddr          = pos[5:2];
        wdata          = byte_word;
        core_ctl.start = (state_reg == B_KICK);
        core_ctl.init  = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    if (q_data.byte_present) begin
                        word_next      = byte_word;
                        we             = (pos[1:0] == 2'd3);
                        bit_count_next = bit_count_reg + 64'd8;
                        if (pos == 6'd63) begin
                            ret_next   = q_data.last ? B_PAD : B_IDLE;
                            state_next = B_KICK;
                        end else if (q_data.last) begin
                            state_next = B_PAD;
                        end
                    end else if (q_data.last) begin
                        state_next = B_PAD;
                    end
                end
            end
            B_PAD: begin
                we    = 1'b1;
                wdata = pad_word;
                if (pos[5:2] == 4'd15) begin
                    widx_next    = '0;
                    two_blk_next = 1'b0;
                    ret_next     = B_FILL;
                    state_next   = B_KICK;
                end else begin
                    widx_next    = pos[5:2] + 4'd1;
                    two_blk_next = (pos >= 6'd56);
                    state_next   = B_FILL;
                end
            end
            B_FILL: begin
                we    = 1'b1;
                waddr = widx_reg;
                if (two_blk_reg || widx_reg < 4'd14) begin
                    wdata = '0;
                end else if (widx_reg == 4'd14) begin
                    wdata = bit_count_reg[31:0];
                end else begin
                    wdata = bit_count_reg[63:32];
                end
                widx_next = widx_reg + 4'd1;
                if (widx_reg == 4'd15) begin
                    state_next   = B_KICK;
                    ret_next     = two_blk_reg ? B_FILL : B_DONE;
                    two_blk_next = 1'b0;
                end
            end
            B_KICK: state_next = B_WAIT;
            B_WAIT: begin
                if (core_sts.done) begin
                    state_next = ret_reg;
                end
            end
            B_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next       = 1'b1;
                    out_next.digest_high = {bswap32(chain[127:96]), bswap32(chain[95:64])};
                    out_next.digest_low  = {bswap32(chain[63:32]), bswap32(chain[31:0])};
                    core_ctl.init        = 1'b1;
                    bit_count_next       = '0;
                    state_next           = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            ret_reg       <= B_IDLE;
            bit_count_reg <= '0;
            widx_reg      <= '0;
            two_blk_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            bit_count_reg <= bit_count_next;
            widx_reg      <= widx_next;
            two_blk_reg   <= two_blk_next;
            out_valid_reg <= out_valid_next;
        end
        word_reg <= word_next;
        out_reg  <= out_next;
    end

    // buffer must stay untouched while a compression reads it
    a_no_write_in_compress: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> (state_reg != B_WAIT && state_reg != B_KICK))
        else $error("block buffer written during compression");

    a_digest_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == B_DONE))
        else $error("digest loaded outside finish state");

    a_fill_end_kicks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_FILL && widx_reg == 4'd15) |=> state_reg == B_KICK)
        else $error("padding block end did not start compression");

    a_count_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DONE && state_next == B_IDLE) |=> bit_count_reg == 64'd0)
        else $error("bit count not cleared after digest");
endmodule

// ===== src/md5_message_digest.sv =====
// md5_message_digest: top level of the streaming MD5 hasher.
// Depends on md5_pkg, md5_front and md5_back.
//
//   channel   direction  payload                              handshake
//   s_        in         data_byte, byte_present, last        s_valid / s_ready
//   m_        out        digest_high, digest_low              m_valid / m_ready
//
// The back end takes byte beats while idle; every 64th byte adds a kick state and a
// compression (one MD5 round per cycle on the shared round unit). A last beat adds
// padding writes plus one or two compressions before the digest. A two-entry queue
// keeps taking beats, until it is full, while the back end compresses. Reset is
// synchronous, active low, and loads the initial chaining words. A stalled m_ only
// blocks the next digest.
`timescale 1ns / 1ps
module md5_message_digest (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  md5_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output md5_pkg::out_t m_data
);
    import md5_pkg::*;

    logic q_valid;
    logic q_ready;
    in_t  q_data;

    md5_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    md5_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );
endmodule
